// ----- hdl/xrke_pkg.sv -----
// ---------------------------------------------------------------------------
// xrke_pkg: shared types and constants for the RSA key extractor
// Item structs, parse phases, status codes and the rsaEncryption OID table.
// ---------------------------------------------------------------------------
package xrke_pkg;

	localparam int MaxLengthBytes = 4;
	localparam logic [32:0] PosMax = 33'h1_FFFF_FFFF;

	typedef struct packed {
		logic [7:0] cert_byte;
		logic       end_of_cert;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  value;
		logic [31:0] modulus_bytes;
		logic        run_end;
	} out_item_t;

	typedef enum logic [4:0] {
		PH_CERT    = 5'd0,
		PH_TBS     = 5'd1,
		PH_VER     = 5'd2,
		PH_SERIAL  = 5'd3,
		PH_F4      = 5'd4,
		PH_F5      = 5'd5,
		PH_F6      = 5'd6,
		PH_SUBJECT = 5'd7,
		PH_SPKI    = 5'd8,
		PH_ALG     = 5'd9,
		PH_OID     = 5'd10,
		PH_BIT     = 5'd11,
		PH_RSASEQ  = 5'd12,
		PH_MOD     = 5'd13,
		PH_EXP     = 5'd14,
		PH_ALGREST = 5'd15,
		PH_UNUSED  = 5'd16,
		PH_DONE    = 5'd17
	} phase_t;

	typedef enum logic [1:0] {
		HS_TAG     = 2'd0,
		HS_LEN     = 2'd1,
		HS_LONG    = 2'd2,
		HS_CONTENT = 2'd3
	} hstep_t;

	localparam logic [1:0] KIND_MOD    = 2'd0;
	localparam logic [1:0] KIND_EXP    = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_MALF   = 2'd1;
	localparam logic [1:0] ERR_NOTRSA = 2'd2;

	localparam logic [7:0] TAG_SEQ  = 8'h30;
	localparam logic [7:0] TAG_INT  = 8'h02;
	localparam logic [7:0] TAG_BIT  = 8'h03;
	localparam logic [7:0] TAG_OID  = 8'h06;
	localparam logic [7:0] TAG_VER  = 8'hA0;
	localparam int         OidLen   = 9;

	function automatic logic [7:0] rsa_oid(input logic [3:0] idx);
		unique case (idx)
			4'd0:    rsa_oid = 8'h2a;
			4'd1:    rsa_oid = 8'h86;
			4'd2:    rsa_oid = 8'h48;
			4'd3:    rsa_oid = 8'h86;
			4'd4:    rsa_oid = 8'hf7;
			4'd5:    rsa_oid = 8'h0d;
			4'd6:    rsa_oid = 8'h01;
			4'd7:    rsa_oid = 8'h01;
			4'd8:    rsa_oid = 8'h01;
			default: rsa_oid = 8'h00;
		endcase
	endfunction

	// Container index bounding a header phase; 7 means unbounded.
	function automatic logic [2:0] lim_of(input phase_t ph);
		unique case (ph)
			PH_CERT:                    lim_of = 3'd7;
			PH_TBS:                     lim_of = 3'd0;
			PH_ALG, PH_BIT:             lim_of = 3'd2;
			PH_OID:                     lim_of = 3'd3;
			PH_RSASEQ, PH_MOD, PH_EXP:  lim_of = 3'd4;
			default:                    lim_of = 3'd1;
		endcase
	endfunction

	// Required tag and whether one is required.
	function automatic logic [8:0] tag_of(input phase_t ph);
		unique case (ph)
			PH_CERT, PH_TBS, PH_SPKI, PH_ALG, PH_RSASEQ: tag_of = {1'b1, TAG_SEQ};
			PH_OID:                                     tag_of = {1'b1, TAG_OID};
			PH_BIT:                                     tag_of = {1'b1, TAG_BIT};
			PH_MOD, PH_EXP:                             tag_of = {1'b1, TAG_INT};
			default:                                    tag_of = 9'd0;
		endcase
	endfunction

	function automatic logic [32:0] sat33(input logic [33:0] v);
		sat33 = v[33] ? PosMax : v[32:0];
	endfunction

endpackage

// ----- hdl/x509_rsa_key_extractor.sv -----
// ---------------------------------------------------------------------------
// x509_rsa_key_extractor: stream an RSA public key out of a DER certificate
// Parses one certificate byte per item, emits modulus and exponent bytes,
// and a status item on the last byte, with the modulus length if the status is good.
// ---------------------------------------------------------------------------
// A result is written into the result queue when its byte is accepted.
// Throughput: one byte per cycle while the queue has room; a byte that yields a
//   key byte and the status queues both, and the single output port sends them in turn.
// Reset: arst_n clears the parse state to await a certificate header and
//   empties the result queue; container ends need no reset.
module x509_rsa_key_extractor import xrke_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic      step, room;
	logic      key_vld, stat_vld;
	out_item_t key_res, stat_res, key_fix;

	// accept while the queue can take two more results
	assign in_stall = !room;
	assign step     = in_valid && !in_stall;

	xrke_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.item     (in_data),
		.key_vld  (key_vld),
		.key_res  (key_res),
		.stat_vld (stat_vld),
		.stat_res (stat_res)
	);

	// key byte closes the run unless the status follows it
	always_comb begin
		key_fix         = key_res;
		key_fix.run_end = !stat_vld;
	end

	xrke_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push_a (step && key_vld),
		.data_a (key_fix),
		.push_b (step && stat_vld),
		.data_b (stat_res),
		.room   (room),
		.valid  (out_valid),
		.data   (out_data),
		.stall  (out_stall)
	);

	a_status_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == KIND_STATUS |-> out_data.run_end)
		else $error("status item without run end");

	a_count_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.value != 8'd0 && out_data.kind == KIND_STATUS
		|-> out_data.modulus_bytes == 32'd0)
		else $error("modulus count with bad status");

	a_key_zero_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind != KIND_STATUS |-> out_data.modulus_bytes == 32'd0)
		else $error("key item carries count");

endmodule

// ----- hdl/xrke_parser.sv -----
// ---------------------------------------------------------------------------
// xrke_parser: DER walk state and one-byte next-state logic
// Holds all parse state and turns one accepted byte into up to two results.
// ---------------------------------------------------------------------------
module xrke_parser import xrke_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  item,
	output logic      key_vld,
	output out_item_t key_res,
	output logic      stat_vld,
	output out_item_t stat_res
);

	phase_t      phase_q, ph_n, ph_eff;
	hstep_t      hstep_q, hs_n;
	logic [31:0] lacc_q, lacc_n;
	logic [2:0]  lleft_q, lleft_n;
	logic [32:0] pos_q, npos;
	logic [32:0] ends_q [6];
	logic [32:0] ends_n [6];
	logic [3:0]  oidx_q, oidx_n;
	logic        odiff_q, odiff_n;
	logic [1:0]  ferr_q, ferr_n;
	logic [31:0] mcnt_q, mcnt_n;
	logic        ais_q, ais_n;

	logic [7:0]  b;
	logic [2:0]  li;
	logic        has_lim;
	logic [32:0] lim, e;
	logic [8:0]  want;
	logic        hdr_err, hdr_fin;
	logic [31:0] lacc_h;
	logic        cdone;
	phase_t      cd_ph;
	logic        cd_fail2;
	logic        overrun;
	logic [1:0]  status;

	assign b    = item.cert_byte;
	assign npos = sat33({1'b0, pos_q} + 34'd1);

	always_comb begin
		ph_n     = phase_q;
		hs_n     = hstep_q;
		lacc_n   = lacc_q;
		lleft_n  = lleft_q;
		ends_n   = ends_q;
		oidx_n   = oidx_q;
		odiff_n  = odiff_q;
		ferr_n   = ferr_q;
		mcnt_n   = mcnt_q;
		ais_n    = ais_q;
		key_vld  = 1'b0;
		key_res  = '0;
		ph_eff   = phase_q;
		hdr_err  = 1'b0;
		hdr_fin  = 1'b0;
		lacc_h   = lacc_q;
		e        = '0;
		cdone    = 1'b0;
		cd_ph    = phase_q;
		cd_fail2 = 1'b0;
		li       = 3'd7;
		has_lim  = 1'b0;
		lim      = '0;
		want     = '0;

		if (phase_q <= PH_EXP && hstep_q == HS_CONTENT) begin
			// content byte
			if (phase_q == PH_OID) begin
				if (oidx_q < 4'(OidLen)) begin
					if (b != rsa_oid(oidx_q)) odiff_n = 1'b1;
				end else begin
					odiff_n = 1'b1;
				end
				if (oidx_q != 4'd15) oidx_n = oidx_q + 4'd1;
			end else if (phase_q == PH_MOD || phase_q == PH_EXP) begin
				if (!(ais_q && b == 8'd0)) begin
					key_vld       = 1'b1;
					key_res.kind  = (phase_q == PH_MOD) ? KIND_MOD : KIND_EXP;
					key_res.value = b;
					if (phase_q == PH_MOD && mcnt_q != 32'hFFFF_FFFF)
						mcnt_n = mcnt_q + 32'd1;
				end
				ais_n = 1'b0;
			end
			if (npos >= ends_q[5]) cdone = 1'b1;
			cd_ph = phase_q;
		end else if (phase_q <= PH_EXP) begin
			// header byte
			if (phase_q == PH_VER && hstep_q == HS_TAG && b != TAG_VER) ph_eff = PH_SERIAL;
			ph_n    = ph_eff;
			li      = lim_of(ph_eff);
			has_lim = (li != 3'd7);
			lim     = has_lim ? ends_q[li] : '0;
			want    = tag_of(ph_eff);
			if (has_lim && pos_q >= lim) begin
				hdr_err = 1'b1;
			end else begin
				unique case (hstep_q)
					HS_TAG: begin
						if (want[8] && b != want[7:0]) hdr_err = 1'b1;
						else hs_n = HS_LEN;
					end
					HS_LEN: begin
						if (!b[7]) begin
							lacc_h  = {24'd0, b};
							hdr_fin = 1'b1;
						end else if (b[6:0] > 7'(MaxLengthBytes)) begin
							hdr_err = 1'b1;
						end else begin
							lacc_h = '0;
							if (b[6:0] != 7'd0) begin
								lleft_n = b[2:0];
								hs_n    = HS_LONG;
							end else begin
								hdr_fin = 1'b1;
							end
						end
					end
					default: begin
						lacc_h = {lacc_q[23:0], b};
						if (lleft_q > 3'd1) lleft_n = lleft_q - 3'd1;
						else begin
							lleft_n = '0;
							hdr_fin = 1'b1;
						end
					end
				endcase
				lacc_n = lacc_h;
				e = sat33({1'b0, npos} + {2'b0, lacc_h});
				if (hdr_fin && has_lim && e > lim) begin
					hdr_err = 1'b1;
					hdr_fin = 1'b0;
				end
			end
			if (hdr_fin) begin
				hs_n = HS_TAG;
				unique case (ph_eff)
					PH_CERT: begin ends_n[0] = e; ph_n = PH_TBS; end
					PH_TBS:  begin ends_n[1] = e; ph_n = PH_VER; end
					PH_SPKI: begin ends_n[2] = e; ph_n = PH_ALG; end
					PH_ALG:  begin ends_n[3] = e; ph_n = PH_OID; end
					PH_BIT: begin
						if (lacc_h == 32'd0) hdr_err = 1'b1;
						else begin
							ends_n[4] = e;
							ph_n      = PH_UNUSED;
						end
					end
					PH_RSASEQ: ph_n = PH_MOD;
					default: begin
						if (ph_eff == PH_OID && lacc_h != 32'(OidLen)) begin
							ferr_n = (ferr_q == ERR_NONE) ? ERR_NOTRSA : ferr_q;
							ph_n   = PH_DONE;
						end else begin
							ends_n[5] = e;
							oidx_n    = '0;
							odiff_n   = 1'b0;
							ais_n     = 1'b1;
							hs_n      = HS_CONTENT;
							if (e <= npos) begin
								cdone = 1'b1;
								cd_ph = ph_eff;
							end
						end
					end
				endcase
			end
		end else if (phase_q == PH_ALGREST) begin
			if (npos >= ends_q[3]) begin
				ph_n = PH_BIT;
				hs_n = HS_TAG;
			end
		end else if (phase_q == PH_UNUSED) begin
			if (b != 8'd0) hdr_err = 1'b1;
			else begin
				ph_n = PH_RSASEQ;
				hs_n = HS_TAG;
			end
		end

		// close an element's content
		if (cdone) begin
			hs_n = HS_TAG;
			if (cd_ph >= PH_VER && cd_ph <= PH_SUBJECT) begin
				ph_n = phase_t'(cd_ph + 5'd1);
			end else if (cd_ph == PH_OID) begin
				if (odiff_n || oidx_n != 4'(OidLen)) cd_fail2 = 1'b1;
				else ph_n = (npos >= ends_q[3]) ? PH_BIT : PH_ALGREST;
			end else if (cd_ph == PH_MOD) begin
				ph_n = PH_EXP;
			end else begin
				ph_n = PH_DONE;
			end
		end

		if (hdr_err) begin
			if (ferr_q == ERR_NONE) ferr_n = ERR_MALF;
			ph_n = PH_DONE;
			hs_n = HS_TAG;
		end else if (cd_fail2) begin
			if (ferr_q == ERR_NONE) ferr_n = ERR_NOTRSA;
			ph_n = PH_DONE;
			hs_n = HS_TAG;
		end
	end

	// final status
	always_comb begin
		overrun = (ph_n == PH_CERT) || (ends_n[0] > npos);
		if (overrun) status = ERR_MALF;
		else if (ferr_n != ERR_NONE) status = ferr_n;
		else status = (ph_n == PH_DONE) ? ERR_NONE : ERR_MALF;
		stat_vld               = item.end_of_cert;
		stat_res.kind          = KIND_STATUS;
		stat_res.value         = {6'd0, status};
		stat_res.modulus_bytes = (status == ERR_NONE) ? mcnt_n : 32'd0;
		stat_res.run_end       = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CERT;
			hstep_q <= HS_TAG;
			lacc_q  <= '0;
			lleft_q <= '0;
			pos_q   <= '0;
			oidx_q  <= '0;
			odiff_q <= 1'b0;
			ferr_q  <= ERR_NONE;
			mcnt_q  <= '0;
			ais_q   <= 1'b0;
		end else if (step) begin
			if (item.end_of_cert) begin
				phase_q <= PH_CERT;
				hstep_q <= HS_TAG;
				lacc_q  <= '0;
				lleft_q <= '0;
				pos_q   <= '0;
				oidx_q  <= '0;
				odiff_q <= 1'b0;
				ferr_q  <= ERR_NONE;
				mcnt_q  <= '0;
				ais_q   <= 1'b0;
			end else begin
				phase_q <= ph_n;
				hstep_q <= hs_n;
				lacc_q  <= lacc_n;
				lleft_q <= lleft_n;
				pos_q   <= npos;
				oidx_q  <= oidx_n;
				odiff_q <= odiff_n;
				ferr_q  <= ferr_n;
				mcnt_q  <= mcnt_n;
				ais_q   <= ais_n;
			end
		end
	end

	// container ends: written before read, no reset
	always_ff @(posedge clk) begin
		if (step) ends_q <= ends_n;
	end

endmodule

// ----- hdl/xrke_outq.sv -----
// ---------------------------------------------------------------------------
// xrke_outq: four-entry result queue
// Buffers up to two results per byte and drains one per cycle while not stalled.
// ---------------------------------------------------------------------------
module xrke_outq import xrke_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_a,
	input  out_item_t data_a,
	input  logic      push_b,
	input  out_item_t data_b,
	output logic      room,
	output logic      valid,
	output out_item_t data,
	input  logic      stall
);

	out_item_t  mem_q [4];
	logic [1:0] rd_q, wr_q;
	logic [2:0] cnt_q;
	logic       pop;
	logic [1:0] npush;

	assign valid = (cnt_q != 3'd0);
	assign data  = mem_q[rd_q];
	assign pop   = valid && !stall;
	assign npush = {1'b0, push_a} + {1'b0, push_b};
	// at least two free slots, not counting this cycle's pop
	assign room  = (cnt_q <= 3'd2);

	always_ff @(posedge clk) begin
		if (push_a) mem_q[wr_q] <= data_a;
		if (push_b) mem_q[push_a ? wr_q + 2'd1 : wr_q] <= data_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + npush;
			if (pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {1'b0, npush} - {2'b0, pop};
		end
	end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the X.509 RSA key extractor
// Feeds DER certificates one byte per item (well-formed, damaged and noise),
// predicts every key byte and status item, and checks the output stream.
// ---------------------------------------------------------------------------
module tb_top;
	import xrke_pkg::*;

	typedef logic [7:0] byte_q_t[$];

	localparam int IdleLimit = 3000;   // cycles with no item moving on either side
	localparam int LongHold  = 300;    // receiver hold-off for the pressure test
	localparam logic [7:0] RsaEncOid [9] = '{8'h2a, 8'h86, 8'h48, 8'h86, 8'hf7,
		8'h0d, 8'h01, 8'h01, 8'h01};
	localparam int NoLimit = 6;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;

	// Expected key bytes and status items, oldest first.
	out_item_t key_results_q[$];

	int mismatches = 0;
	int bytes_sent = 0;
	int tx_max = 17;
	int rx_max = 17;
	int hold_req = 0;
	int idle_cycles = 0;

	// Shadow of the extractor state.
	phase_t      sh_phase;
	hstep_t      sh_step;
	logic [31:0] sh_len;
	logic [2:0]  sh_len_left;
	logic [32:0] sh_pos;
	logic [32:0] sh_ends [6];
	logic [3:0]  sh_oid_idx;
	logic        sh_oid_diff;
	logic [1:0]  sh_first_err;
	logic [31:0] sh_mod_cnt;
	logic        sh_int_start;
	logic [32:0] sh_cur;
	logic [32:0] sh_next;

	x509_rsa_key_extractor dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------------
	// Key extraction predictor
	// ---------------------------------------------------------------------
	function automatic void clear_parser();
		sh_phase = PH_CERT;
		sh_step = HS_TAG;
		sh_len = '0;
		sh_len_left = '0;
		sh_pos = '0;
		foreach (sh_ends[i]) sh_ends[i] = '0;
		sh_oid_idx = '0;
		sh_oid_diff = 1'b0;
		sh_first_err = ERR_NONE;
		sh_mod_cnt = '0;
		sh_int_start = 1'b0;
	endfunction

	function automatic logic [32:0] clamp_pos(logic [63:0] v);
		return (v > {31'd0, PosMax}) ? PosMax : v[32:0];
	endfunction

	function automatic void push_result(logic [1:0] kind, logic [7:0] value,
			logic [31:0] cnt);
		out_item_t r;
		r.kind = kind;
		r.value = value;
		r.modulus_bytes = cnt;
		r.run_end = 1'b0;
		key_results_q.push_back(r);
	endfunction

	function automatic void abort_parse(logic [1:0] code);
		if (sh_first_err == ERR_NONE)
			sh_first_err = code;
		sh_phase = PH_DONE;
		sh_step = HS_TAG;
	endfunction

	// Container that bounds each header phase; NoLimit for the outer header.
	function automatic int bound_of(phase_t p);
		case (p)
			PH_CERT:                   return NoLimit;
			PH_TBS:                    return 0;
			PH_ALG, PH_BIT:            return 2;
			PH_OID:                    return 3;
			PH_RSASEQ, PH_MOD, PH_EXP: return 4;
			default:                   return 1;
		endcase
	endfunction

	// Tag each header phase demands; -1 takes any tag.
	function automatic int tag_needed(phase_t p);
		case (p)
			PH_CERT, PH_TBS, PH_SPKI, PH_ALG, PH_RSASEQ: return TAG_SEQ;
			PH_OID:                                     return TAG_OID;
			PH_BIT:                                     return TAG_BIT;
			PH_MOD, PH_EXP:                             return TAG_INT;
			default:                                    return -1;
		endcase
	endfunction

	// -1 error, 0 header pending, 1 header done with content end in e.
	function automatic int take_header(logic [7:0] b, bit has_lim, logic [32:0] lim,
			int want, output logic [32:0] e);
		logic [7:0] cnt;
		e = '0;
		if (has_lim && sh_cur >= lim)
			return -1;
		if (sh_step == HS_TAG) begin
			if (want >= 0 && b != want[7:0])
				return -1;
			sh_step = HS_LEN;
			return 0;
		end
		if (sh_step == HS_LEN) begin
			if (b < 8'h80) begin
				sh_len = {24'd0, b};
			end else begin
				cnt = b & 8'h7f;
				if (cnt > MaxLengthBytes)
					return -1;
				sh_len = '0;
				if (cnt != 0) begin
					sh_len_left = cnt[2:0];
					sh_step = HS_LONG;
					return 0;
				end
			end
		end else begin
			sh_len = {sh_len[23:0], b};
			if (sh_len_left > 1) begin
				sh_len_left = sh_len_left - 3'd1;
				return 0;
			end
			sh_len_left = '0;
		end
		e = clamp_pos({31'd0, sh_next} + {32'd0, sh_len});
		if (has_lim && e > lim)
			return -1;
		return 1;
	endfunction

	function automatic void finish_content(phase_t p);
		sh_step = HS_TAG;
		if (p >= PH_VER && p <= PH_SUBJECT) begin
			sh_phase = phase_t'(p + 5'd1);
		end else if (p == PH_OID) begin
			if (sh_oid_diff || sh_oid_idx != OidLen) begin
				abort_parse(ERR_NOTRSA);
				return;
			end
			sh_phase = (sh_next >= sh_ends[3]) ? PH_BIT : PH_ALGREST;
		end else if (p == PH_MOD) begin
			sh_phase = PH_EXP;
		end else begin
			sh_phase = PH_DONE;
		end
	endfunction

	function automatic void finish_header(phase_t p, logic [32:0] e);
		sh_step = HS_TAG;
		case (p)
			PH_CERT: begin
				sh_ends[0] = e;
				sh_phase = PH_TBS;
			end
			PH_TBS: begin
				sh_ends[1] = e;
				sh_phase = PH_VER;
			end
			PH_SPKI: begin
				sh_ends[2] = e;
				sh_phase = PH_ALG;
			end
			PH_ALG: begin
				sh_ends[3] = e;
				sh_phase = PH_OID;
			end
			PH_BIT: begin
				if (sh_len == 0) begin
					abort_parse(ERR_MALF);
					return;
				end
				sh_ends[4] = e;
				sh_phase = PH_UNUSED;
			end
			PH_RSASEQ: sh_phase = PH_MOD;
			default: begin
				if (p == PH_OID && sh_len != OidLen) begin
					abort_parse(ERR_NOTRSA);
					return;
				end
				sh_ends[5] = e;
				sh_oid_idx = '0;
				sh_oid_diff = 1'b0;
				sh_int_start = 1'b1;
				sh_step = HS_CONTENT;
				if (e <= sh_next)
					finish_content(p);
			end
		endcase
	endfunction

	function automatic void take_content(phase_t p, logic [7:0] b);
		if (p == PH_OID) begin
			if (sh_oid_idx < OidLen) begin
				if (b != RsaEncOid[sh_oid_idx])
					sh_oid_diff = 1'b1;
			end else begin
				sh_oid_diff = 1'b1;
			end
			if (sh_oid_idx < 15)
				sh_oid_idx = sh_oid_idx + 4'd1;
		end else if (p == PH_MOD || p == PH_EXP) begin
			if (!(sh_int_start && b == 8'h00)) begin
				push_result((p == PH_MOD) ? KIND_MOD : KIND_EXP, b, '0);
				if (p == PH_MOD && sh_mod_cnt != 32'hffff_ffff)
					sh_mod_cnt = sh_mod_cnt + 32'd1;
			end
			sh_int_start = 1'b0;
		end
		if (sh_next >= sh_ends[5])
			finish_content(p);
	endfunction

	// Advance the shadow by one certificate byte and queue what it yields.
	function automatic void parse_byte(logic [7:0] b, logic last);
		phase_t p;
		int n0;
		int li;
		int r;
		logic [32:0] e;
		logic [1:0] status;
		bit overrun;
		p = sh_phase;
		n0 = key_results_q.size();
		sh_cur = sh_pos;
		sh_next = clamp_pos({31'd0, sh_cur} + 64'd1);
		if (p <= PH_EXP) begin
			if (sh_step == HS_CONTENT) begin
				take_content(p, b);
			end else begin
				// version is optional: any other tag is already the serial
				if (p == PH_VER && sh_step == HS_TAG && b != TAG_VER) begin
					p = PH_SERIAL;
					sh_phase = PH_SERIAL;
				end
				li = bound_of(p);
				r = take_header(b, li != NoLimit, (li != NoLimit) ? sh_ends[li] : '0,
					tag_needed(p), e);
				if (r < 0)
					abort_parse(ERR_MALF);
				else if (r > 0)
					finish_header(p, e);
			end
		end else if (p == PH_ALGREST) begin
			if (sh_next >= sh_ends[3]) begin
				sh_phase = PH_BIT;
				sh_step = HS_TAG;
			end
		end else if (p == PH_UNUSED) begin
			if (b != 8'h00) begin
				abort_parse(ERR_MALF);
			end else begin
				sh_phase = PH_RSASEQ;
				sh_step = HS_TAG;
			end
		end
		sh_pos = sh_next;
		if (last) begin
			// a certificate running past the buffer overrides earlier codes
			overrun = (sh_phase == PH_CERT) || (sh_ends[0] > sh_next);
			if (overrun)
				status = ERR_MALF;
			else if (sh_first_err != ERR_NONE)
				status = sh_first_err;
			else
				status = (sh_phase == PH_DONE) ? ERR_NONE : ERR_MALF;
			push_result(KIND_STATUS, {6'd0, status}, (status == ERR_NONE) ? sh_mod_cnt : '0);
			clear_parser();
		end
		if (key_results_q.size() > n0)
			key_results_q[key_results_q.size() - 1].run_end = 1'b1;
	endfunction

	// ---------------------------------------------------------------------
	// Certificate builders
	// ---------------------------------------------------------------------
	function automatic byte_q_t rnd_bytes(int n);
		byte_q_t q;
		for (int i = 0; i < n; i++)
			q.push_back(8'($urandom_range(0, 255)));
		return q;
	endfunction

	// lf: 0 shortest form, 1..4 long form with that many length bytes, -1 random.
	function automatic byte_q_t tlv(logic [7:0] tag, byte_q_t c, int lf);
		byte_q_t r;
		int n;
		int len;
		len = c.size();
		if (lf < 0)
			lf = $urandom_range(0, 4);
		r.push_back(tag);
		if (lf == 0 && len < 128) begin
			r.push_back(len[7:0]);
		end else begin
			n = (lf == 0) ? ((len > 255) ? 2 : 1) : lf;
			r.push_back(8'h80 | n[7:0]);
			for (int i = n - 1; i >= 0; i--)
				r.push_back(8'((len >> (8 * i)) & 255));
		end
		r = {r, c};
		return r;
	endfunction

	// oid_mode: 0 rsaEncryption, 1 one byte changed, 2 one byte short, 3 one extra.
	// mlen < 0 gives an empty BIT STRING.
	function automatic byte_q_t make_cert(bit with_ver, int mlen, bit lead0,
			bit params, int oid_mode, logic [7:0] unused, int lf);
		byte_q_t tbs, oid, alg, modc, expc, bits, q;
		if (with_ver)
			tbs = tlv(TAG_VER, tlv(TAG_INT, {8'h02}, lf), lf);
		for (int i = 0; i < 5; i++)
			tbs = {tbs, tlv(8'($urandom_range(0, 255)), rnd_bytes($urandom_range(0, 3)), lf)};
		foreach (RsaEncOid[i])
			oid.push_back(RsaEncOid[i]);
		case (oid_mode)
			1: oid[$urandom_range(0, 8)] ^= 8'(1 << $urandom_range(0, 7));
			2: void'(oid.pop_back());
			3: oid.push_back(8'($urandom_range(0, 255)));
			default: ;
		endcase
		alg = tlv(TAG_OID, oid, lf);
		if (params)
			alg = {alg, 8'h05, 8'h00};
		alg = tlv(TAG_SEQ, alg, lf);
		if (mlen < 0) begin
			bits = {TAG_BIT, 8'h00};
		end else begin
			modc = rnd_bytes(mlen);
			if (lead0)
				modc.push_front(8'h00);
			expc = {8'h01, 8'h00, 8'h01};
			q = tlv(TAG_SEQ, {tlv(TAG_INT, modc, lf), tlv(TAG_INT, expc, lf)}, lf);
			bits = tlv(TAG_BIT, {unused, q}, lf);
		end
		tbs = {tbs, tlv(TAG_SEQ, {alg, bits}, lf)};
		q = tlv(TAG_SEQ, {tlv(TAG_SEQ, tbs, lf), rnd_bytes($urandom_range(0, 4))}, lf);
		return q;
	endfunction

	// ---------------------------------------------------------------------
	// Driving
	// ---------------------------------------------------------------------
	task automatic send_byte(logic [7:0] b, logic last);
		int gap;
		gap = $urandom_range(0, tx_max);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{cert_byte: b, end_of_cert: last};
		do @(posedge clk); while (in_stall);
		parse_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_cert(byte_q_t c);
		foreach (c[i])
			send_byte(c[i], i == c.size() - 1);
	endtask

	// Hold the sender until every expected item is out.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (key_results_q.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------
	task automatic test_well_formed();
		send_cert(make_cert(1, 4, 1, 0, 0, 8'h00, 0));
		drain();
		send_cert(make_cert(0, 3, 0, 1, 0, 8'h00, 4));
		send_cert(make_cert(1, 0, 1, 0, 0, 8'h00, 1));    // modulus of a single zero
		send_cert(make_cert(0, 0, 0, 0, 0, 8'h00, 2));    // empty modulus
		drain();
	endtask

	task automatic test_bad_certs();
		send_cert({TAG_SEQ, 8'h85, 8'h00, 8'h00, 8'h00, 8'h00, 8'h10});  // five length bytes
		send_cert({TAG_SEQ, 8'h03, 8'h31, 8'h01, 8'h00});                // wrong tbs tag
		send_cert({TAG_SEQ});                                            // header cut short
		send_cert({TAG_SEQ, 8'h80});                                     // zero-length cert
		send_cert({8'hff, 8'h00});
		send_cert(make_cert(0, 2, 0, 0, 1, 8'h00, 0));    // other algorithm
		send_cert(make_cert(0, 2, 0, 0, 2, 8'h00, 0));    // OID too short
		send_cert(make_cert(0, 2, 0, 1, 3, 8'h00, 0));    // OID too long
		send_cert(make_cert(1, 2, 0, 0, 0, 8'h80, 0));    // unused bits set
		send_cert(make_cert(0, -1, 0, 0, 0, 8'h00, 0));   // empty BIT STRING
		begin
			byte_q_t c;
			c = make_cert(1, 3, 0, 0, 0, 8'h00, 0);
			c = c[0:c.size() - 3];                        // buffer ends inside cert
			send_cert(c);
		end
		drain();
	endtask

	// Hold the receiver long enough for the block to fill and stall its input.
	task automatic test_backpressure();
		tx_max = 0;
		hold_req = LongHold;
		send_cert(make_cert(1, 40, 0, 0, 0, 8'h00, 0));
		drain();
		tx_max = 17;
	endtask

	task automatic test_random_certs();
		byte_q_t c;
		int goal;
		int k;
		// top the run up to about 550 bytes, with a few random certificates at least
		goal = (bytes_sent + 100 > 550) ? bytes_sent + 100 : 550;
		while (bytes_sent < goal) begin
			// switch idling on and off per certificate
			tx_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
			rx_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
			k = $urandom_range(0, 9);
			if (k == 0) begin
				c = rnd_bytes($urandom_range(1, 8));
			end else begin
				c = make_cert(1'($urandom_range(0, 1)), $urandom_range(0, 12),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0,
					($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00, -1);
				if (k == 1)
					c[$urandom_range(0, c.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
				else if (k == 2)
					c = c[0:$urandom_range(0, c.size() - 1)];
			end
			send_cert(c);
			if ($urandom_range(0, 7) == 0)
				drain();
		end
		tx_max = 17;
		rx_max = 17;
	endtask

	// ---------------------------------------------------------------------
	// Receiver: stall per item, with one long hold-off on request
	// ---------------------------------------------------------------------
	initial begin
		int k;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				k = hold_req;
				hold_req = 0;
			end else begin
				k = $urandom_range(0, rx_max);
			end
			if (k > 0) begin
				out_stall <= 1'b1;
				repeat (k) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// Check each output item against the oldest expectation.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (key_results_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: kind %0d value %0h count %0d end %0b",
						out_data.kind, out_data.value, out_data.modulus_bytes,
						out_data.run_end);
			end else begin
				want = key_results_q.pop_front();
				if (out_data !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected kind %0d value %0h count %0d end %0b, got kind %0d value %0h count %0d end %0b",
							want.kind, want.value, want.modulus_bytes, want.run_end,
							out_data.kind, out_data.value, out_data.modulus_bytes,
							out_data.run_end);
				end
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin
		clear_parser();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_well_formed();
		test_bad_certs();
		test_backpressure();
		test_random_certs();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (key_results_q.size() == 0);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
